@@ rtl/msp_pkg.sv @@
package msp_pkg;

  localparam logic [7:0]  HDR_DOLLAR    = 8'h24;
  localparam logic [7:0]  HDR_M         = 8'h4D;
  localparam logic [7:0]  HDR_LT        = 8'h3C;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    EV_BYTE    = 3'd0,
    EV_GOOD    = 3'd1,
    EV_BADSUM  = 3'd2,
    EV_BADCODE = 3'd3,
    EV_TIMEOUT = 3'd4
  } event_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] code;
    logic [7:0] size;
    logic [7:0] idx;
    logic [7:0] data;
  } res_t;

endpackage

@@ rtl/msp_v1_frame_receiver.sv @@
// Request deframer for '$' 'M' '<' size code payload checksum frames.
// Input channel: in_valid/in_stall with in_operation (0 byte, 1 tick) and
// in_rx_byte. An item is taken when in_valid is high and in_stall is low.
// Result channel: out_valid/out_stall with event, code, size, index and data.
// Each item yields zero or one result: a payload byte with its index, or an
// end status (frame good, checksum bad, code invalid, timeout).
// A result goes into the output register when the output is free, else into the skid register.
// Throughput: one item per cycle while in_stall is low, set by the single state
// update between the input handshake and the result register.
// When the receiver stalls, a further result is held in a one-entry skid
// register; in_stall rises only once that entry is full, so no item is lost.
// cfg_valid/cfg_ready/cfg_data write the payload timeout budget in ticks;
// cfg_ready is always high. The budget is loaded at each non-zero code byte.
// Reset (rst_n low, synchronous) returns to hunting for '$', empties the
// output and skid registers and sets the budget to 1000 ticks.
module msp_v1_frame_receiver
  import msp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_command_code,
  output logic [7:0]  out_payload_size,
  output logic [7:0]  out_byte_index,
  output logic [7:0]  out_payload_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_M, PH_LT, PH_SIZE, PH_CODE, PH_PAYLOAD, PH_CHECK
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  frame_size_r, frame_size_nxt;
  logic [7:0]  frame_code_r, frame_code_nxt;
  logic [7:0]  bytes_taken_r, bytes_taken_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic [15:0] ticks_left_r, ticks_left_nxt;
  logic [15:0] timeout_r;

  logic        out_valid_r, skid_valid_r;
  res_t        out_r, skid_r;
  logic        accept, res_v, out_free;
  res_t        res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    phase_nxt       = phase_r;
    frame_size_nxt  = frame_size_r;
    frame_code_nxt  = frame_code_r;
    bytes_taken_nxt = bytes_taken_r;
    running_xor_nxt = running_xor_r;
    ticks_left_nxt  = ticks_left_r;
    res_v           = 1'b0;
    res.ev          = EV_BYTE;
    res.idx         = 8'd0;
    res.data        = 8'd0;
    if (in_operation == OP_TICK) begin
      if (phase_r == PH_PAYLOAD) begin
        if (ticks_left_r <= 16'd1) begin
          ticks_left_nxt = 16'd0;
          phase_nxt      = PH_HUNT;
          res_v          = 1'b1;
          res.ev         = EV_TIMEOUT;
          res.idx        = bytes_taken_r;
        end else begin
          ticks_left_nxt = ticks_left_r - 16'd1;
        end
      end
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == HDR_DOLLAR) phase_nxt = PH_M;
        end
        PH_M: begin
          phase_nxt = (in_rx_byte == HDR_M) ? PH_LT : PH_HUNT;
        end
        PH_LT: begin
          phase_nxt = (in_rx_byte == HDR_LT) ? PH_SIZE : PH_HUNT;
        end
        PH_SIZE: begin
          frame_size_nxt  = in_rx_byte;
          running_xor_nxt = in_rx_byte;
          phase_nxt       = PH_CODE;
        end
        PH_CODE: begin
          frame_code_nxt  = in_rx_byte;
          bytes_taken_nxt = 8'd0;
          if (in_rx_byte == 8'd0) begin
            phase_nxt = PH_HUNT;
            res_v     = 1'b1;
            res.ev    = EV_BADCODE;
          end else begin
            running_xor_nxt = running_xor_r ^ in_rx_byte;
            ticks_left_nxt  = timeout_r;
            phase_nxt       = (frame_size_r == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_xor_nxt = running_xor_r ^ in_rx_byte;
          bytes_taken_nxt = bytes_taken_r + 8'd1;
          if (bytes_taken_nxt >= frame_size_r) phase_nxt = PH_CHECK;
          res_v    = 1'b1;
          res.ev   = EV_BYTE;
          res.idx  = bytes_taken_r;
          res.data = in_rx_byte;
        end
        PH_CHECK: begin
          phase_nxt = PH_HUNT;
          res_v     = 1'b1;
          res.ev    = (running_xor_r == in_rx_byte) ? EV_GOOD : EV_BADSUM;
          res.idx   = bytes_taken_r;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
    // code and size as they stand after this item
    res.code = frame_code_nxt;
    res.size = frame_size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      frame_size_r  <= 8'd0;
      frame_code_r  <= 8'd0;
      bytes_taken_r <= 8'd0;
      running_xor_r <= 8'd0;
      ticks_left_r  <= 16'd0;
      timeout_r     <= TIMEOUT_RESET;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_r <= cfg_data;
      if (accept) begin
        phase_r       <= phase_nxt;
        frame_size_r  <= frame_size_nxt;
        frame_code_r  <= frame_code_nxt;
        bytes_taken_r <= bytes_taken_nxt;
        running_xor_r <= running_xor_nxt;
        ticks_left_r  <= ticks_left_nxt;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= accept && res_v;
          out_r       <= res;
        end
      end else if (accept && res_v) begin
        skid_valid_r <= 1'b1;
        skid_r       <= res;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_r.ev;
  assign out_command_code = out_r.code;
  assign out_payload_size = out_r.size;
  assign out_byte_index   = out_r.idx;
  assign out_payload_byte = out_r.data;

endmodule

@@ rtl/msp_chk.sv @@
module msp_chk
  import msp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_event_res,
  input logic [7:0] out_command_code,
  input logic [7:0] out_payload_size,
  input logic [7:0] out_byte_index,
  input logic [7:0] out_payload_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res)
      && $stable(out_byte_index) && $stable(out_payload_byte))
    else $error("result dropped or changed while stalled");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_BYTE |-> out_payload_byte == 8'd0)
    else $error("data byte set on an end status");

  a_badcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_BADCODE
      |-> out_command_code == 8'd0 && out_byte_index == 8'd0)
    else $error("code invalid with non-zero code or index");

  a_end_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_GOOD || out_event_res == EV_BADSUM)
      |-> out_byte_index == out_payload_size)
    else $error("frame ended with wrong byte count");

  a_timeout_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_TIMEOUT
      |-> out_byte_index < out_payload_size)
    else $error("timeout after payload complete");

endmodule

bind msp_v1_frame_receiver msp_chk u_msp_chk (.*);
